>>> rtl/hbs_pkg.sv
// shared types, widths and constants of the heightmap bilinear sampler
package hbs_pkg;

    localparam int RES_DEFAULT = 64;
    localparam int QUEUE_DEPTH = 8;

    localparam int IDX_W  = 12;
    localparam int HGT_W  = 24;
    localparam int POS_W  = 20;
    localparam int INV_W  = 24;
    localparam int FRAC_W = 8;
    localparam int WGT_W  = FRAC_W + 1;
    localparam int W2_W   = 2 * FRAC_W + 1;
    localparam int CRD_W  = 8;

    localparam logic [INV_W-1:0] INV_RESET = 24'h010000;
    localparam logic [WGT_W-1:0] ONE_Q8    = 9'd256;
    localparam int               HALF_CELL = 128;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        logic                     is_query;
        logic                     wr_en;
        logic [CRD_W-1:0]         row0;
        logic [CRD_W-1:0]         row1;
        logic [CRD_W-1:0]         col0;
        logic [CRD_W-1:0]         col1;
        logic [WGT_W-1:0]         tx;
        logic [WGT_W-1:0]         ty;
        logic signed [HGT_W-1:0]  wdata;
    } t_cmd;

endpackage

>>> rtl/heightmap_bilinear_sampler_unit.sv
// top level of the heightmap bilinear sampler
//
//  channel   direction  handshake                 payload
//  input     in         push / full               i_op, i_sample_index, i_sample_height,
//                                                 i_pos_x, i_pos_y
//  result    out        empty / pop               o_height_out
//  config    in         i_cfg_we (no stall)       i_cfg_wdata
//
// one transaction per cycle while full is low and the back is not held by the result queue; from
// the accepting edge the scale registers load, then the cell split, the command queue, the bank
// read, the products, the sum and the result queue write follow in that order
// four parity banks give the four neighbour samples in one read cycle
// synchronous active-low reset empties both queues; map contents are kept
// full rises when the command queue cannot take what the front holds; the back
// stops issuing when the result queue has no room for what is in flight
module heightmap_bilinear_sampler_unit import hbs_pkg::*; #(
    parameter int RES     = RES_DEFAULT,
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_op,
    input  logic [IDX_W-1:0]        i_sample_index,
    input  logic signed [HGT_W-1:0] i_sample_height,
    input  logic [POS_W-1:0]        i_pos_x,
    input  logic [POS_W-1:0]        i_pos_y,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [HGT_W-1:0] o_height_out,
    input  logic                    i_cfg_we,
    input  logic [INV_W-1:0]        i_cfg_wdata
);

    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam int CMD_W = $bits(t_cmd);

    logic             w_cmd_push;
    t_cmd             w_cmd_in, w_cmd_out;
    logic [CMD_W-1:0] w_mid_data;
    logic             w_mid_empty;
    logic [CNT_W-1:0] w_mid_count;
    logic             w_cmd_pop;
    logic [CNT_W-1:0] w_out_count;
    logic             w_res_push;
    logic signed [HGT_W-1:0] w_res_data;
    logic [HGT_W-1:0] w_out_data;

    hbs_front #(
        .RES     (RES),
        .Q_DEPTH (Q_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_op            (i_op),
        .i_sample_index  (i_sample_index),
        .i_sample_height (i_sample_height),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_mid_count     (w_mid_count),
        .o_cmd_push      (w_cmd_push),
        .o_cmd           (w_cmd_in)
    );

    hbs_queue #(
        .WIDTH (CMD_W),
        .DEPTH (Q_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_cmd_pop),
        .o_data  (w_mid_data),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    assign w_cmd_out = t_cmd'(w_mid_data);

    hbs_back #(
        .RES     (RES),
        .Q_DEPTH (Q_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_mid_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .i_out_count (w_out_count),
        .o_res_push  (w_res_push),
        .o_res_data  (w_res_data)
    );

    hbs_queue #(
        .WIDTH (HGT_W),
        .DEPTH (Q_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_data),
        .i_pop   (pop),
        .o_data  (w_out_data),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign o_height_out = $signed(w_out_data);

endmodule

>>> rtl/hbs_queue.sv
// small register queue with occupancy count
module hbs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign w_do_push = i_push && (int'(r_count) < DEPTH);
    assign w_do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

>>> rtl/hbs_front.sv
// front end: accepts transactions, scales query positions to cells and weights, splits write indexes
module hbs_front import hbs_pkg::*; #(
    parameter int RES     = RES_DEFAULT,
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_op,
    input  logic [IDX_W-1:0]               i_sample_index,
    input  logic signed [HGT_W-1:0]        i_sample_height,
    input  logic [POS_W-1:0]               i_pos_x,
    input  logic [POS_W-1:0]               i_pos_y,
    input  logic                           i_cfg_we,
    input  logic [INV_W-1:0]               i_cfg_wdata,
    input  logic [$clog2(Q_DEPTH+1)-1:0]   i_mid_count,
    output logic                           o_cmd_push,
    output t_cmd                           o_cmd
);

    localparam int CNT_W    = $clog2(Q_DEPTH + 1);
    localparam int CW       = $clog2(RES);
    localparam int MAP_SIZE = RES * RES;
    localparam int PROD_W   = POS_W + INV_W;
    localparam int S_W      = PROD_W - 16;
    localparam int F_W      = S_W + 1;
    localparam int FL_W     = S_W - FRAC_W;
    localparam int DIV_K    = 21;
    localparam int DIV_M    = ((1 << DIV_K) + RES - 1) / RES;
    localparam int DIV_W    = IDX_W + DIV_K;
    localparam logic [CRD_W-1:0] LAST = CRD_W'(RES - 1);

    typedef struct packed {
        logic [CRD_W-1:0] c0;
        logic [CRD_W-1:0] c1;
        logic [WGT_W-1:0] t;
    } t_axis;

    function automatic t_axis axis_setup(input logic [PROD_W-1:0] prod);
        logic signed [F_W-1:0] f;
        t_axis                 a;
        f = $signed({1'b0, prod[PROD_W-1:16]}) - $signed(F_W'(HALF_CELL));
        if (f[F_W-1]) begin
            a.c0 = '0;
            a.t  = '0;
        end else if (f[S_W-1:FRAC_W] > FL_W'(RES - 1)) begin
            a.c0 = LAST;
            a.t  = ONE_Q8;
        end else begin
            a.c0 = CRD_W'(f[FRAC_W +: CW]);
            a.t  = {1'b0, f[FRAC_W-1:0]};
        end
        a.c1 = (a.c0 == LAST) ? LAST : a.c0 + 1'b1;
        return a;
    endfunction

    logic [INV_W-1:0]        r_inv;
    logic                    r_va;
    t_op                     r_a_op;
    logic [IDX_W-1:0]        r_a_idx;
    logic signed [HGT_W-1:0] r_a_hgt;
    logic [PROD_W-1:0]       r_a_px, r_a_py;
    logic [DIV_W-1:0]        r_a_div;
    logic                    r_vb;
    t_cmd                    r_cmd, n_cmd;
    logic [CNT_W:0]          w_resv;
    logic                    w_accept;
    t_axis                   w_ax, w_ay;
    logic [IDX_W-1:0]        w_row, w_col;

    assign w_resv   = (CNT_W+1)'(i_mid_count) + (CNT_W+1)'(r_va) + (CNT_W+1)'(r_vb);
    assign full     = (int'(w_resv) >= Q_DEPTH);
    assign w_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= INV_RESET;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_inv <= i_cfg_wdata;
            end
            r_va <= w_accept;
            r_vb <= r_va;
        end
    end

    // scale stage
    always_ff @(posedge i_clk) begin
        r_a_op  <= t_op'(i_op);
        r_a_idx <= i_sample_index;
        r_a_hgt <= i_sample_height;
        r_a_px  <= PROD_W'(i_pos_x) * PROD_W'(r_inv);
        r_a_py  <= PROD_W'(i_pos_y) * PROD_W'(r_inv);
        r_a_div <= DIV_W'(i_sample_index) * DIV_W'(DIV_M);
    end

    // cell and weight stage
    always_comb begin
        w_ax  = axis_setup(r_a_px);
        w_ay  = axis_setup(r_a_py);
        w_row = r_a_div[DIV_K +: IDX_W];
        w_col = r_a_idx - IDX_W'(int'(w_row) * RES);
        n_cmd = '0;
        n_cmd.wdata = r_a_hgt;
        if (r_a_op == OP_QUERY) begin
            n_cmd.is_query = 1'b1;
            n_cmd.row0     = w_ay.c0;
            n_cmd.row1     = w_ay.c1;
            n_cmd.col0     = w_ax.c0;
            n_cmd.col1     = w_ax.c1;
            n_cmd.tx       = w_ax.t;
            n_cmd.ty       = w_ay.t;
        end else begin
            n_cmd.wr_en = (int'(r_a_idx) < MAP_SIZE);
            n_cmd.row0  = CRD_W'(w_row[CW-1:0]);
            n_cmd.row1  = CRD_W'(w_row[CW-1:0]);
            n_cmd.col0  = CRD_W'(w_col[CW-1:0]);
            n_cmd.col1  = CRD_W'(w_col[CW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_cmd_push = r_vb;
    assign o_cmd      = r_cmd;

endmodule

>>> rtl/hbs_back.sv
// back end: four parity banks of the map and the bilinear blend
module hbs_back import hbs_pkg::*; #(
    parameter int RES     = RES_DEFAULT,
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  t_cmd                           i_cmd,
    output logic                           o_cmd_pop,
    input  logic [$clog2(Q_DEPTH+1)-1:0]   i_out_count,
    output logic                           o_res_push,
    output logic signed [HGT_W-1:0]        o_res_data
);

    localparam int CNT_W  = $clog2(Q_DEPTH + 1);
    localparam int CW     = $clog2(RES);
    localparam int HB     = (CW > 1) ? CW - 1 : 1;
    localparam int ADDR_W = 2 * HB;
    localparam int BANK_D = 1 << ADDR_W;
    localparam int PRD_W  = HGT_W + W2_W + 1;
    localparam int SUM_W  = PRD_W + 2;

    logic                    w_pop;
    logic [CNT_W:0]          w_resv;
    logic signed [HGT_W-1:0] w_rdata [4];

    logic                    r_vr, r_vd, r_vs;
    logic                    r_r_query, r_d_query;
    logic [1:0]              r_r_s00, r_r_s10, r_r_s01, r_r_s11;
    logic [W2_W-1:0]         r_r_w [4];
    logic signed [PRD_W-1:0] r_d_p [4];
    logic signed [HGT_W-1:0] r_s_data;
    logic [WGT_W-1:0]        w_wx0, w_wy0;
    logic signed [HGT_W-1:0] w_h [4];
    logic signed [SUM_W-1:0] w_sum;

    assign w_resv = (CNT_W+1)'(i_out_count) + (CNT_W+1)'(r_vr) + (CNT_W+1)'(r_vd)
                  + (CNT_W+1)'(r_vs);
    assign w_pop  = i_cmd_valid && (int'(w_resv) < Q_DEPTH);
    assign o_cmd_pop = w_pop;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] BID = 2'(b);
        logic [HGT_W-1:0]  r_mem [BANK_D];
        logic [HGT_W-1:0]  r_rd;
        logic [CRD_W-1:0]  w_row_sel, w_col_sel;
        logic [ADDR_W-1:0] w_addr;
        logic              w_we;

        assign w_row_sel = (i_cmd.row0[0] == BID[1]) ? i_cmd.row0 : i_cmd.row1;
        assign w_col_sel = (i_cmd.col0[0] == BID[0]) ? i_cmd.col0 : i_cmd.col1;
        assign w_addr    = {HB'(w_row_sel >> 1), HB'(w_col_sel >> 1)};
        assign w_we      = w_pop && i_cmd.wr_en
                         && ({i_cmd.row0[0], i_cmd.col0[0]} == BID);

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[w_addr] <= i_cmd.wdata;
            end
            r_rd <= r_mem[w_addr];
        end

        assign w_rdata[b] = $signed(r_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
            r_vd <= 1'b0;
            r_vs <= 1'b0;
        end else begin
            r_vr <= w_pop;
            r_vd <= r_vr;
            r_vs <= r_vd;
        end
    end

    // read stage, weights formed beside the bank reads
    assign w_wx0 = ONE_Q8 - i_cmd.tx;
    assign w_wy0 = ONE_Q8 - i_cmd.ty;

    always_ff @(posedge i_clk) begin
        r_r_query <= i_cmd.is_query;
        r_r_s00   <= {i_cmd.row0[0], i_cmd.col0[0]};
        r_r_s10   <= {i_cmd.row0[0], i_cmd.col1[0]};
        r_r_s01   <= {i_cmd.row1[0], i_cmd.col0[0]};
        r_r_s11   <= {i_cmd.row1[0], i_cmd.col1[0]};
        r_r_w[0]  <= W2_W'(w_wx0 * w_wy0);
        r_r_w[1]  <= W2_W'(i_cmd.tx * w_wy0);
        r_r_w[2]  <= W2_W'(w_wx0 * i_cmd.ty);
        r_r_w[3]  <= W2_W'(i_cmd.tx * i_cmd.ty);
    end

    // product stage
    assign w_h[0] = w_rdata[r_r_s00];
    assign w_h[1] = w_rdata[r_r_s10];
    assign w_h[2] = w_rdata[r_r_s01];
    assign w_h[3] = w_rdata[r_r_s11];

    always_ff @(posedge i_clk) begin
        r_d_query <= r_r_query;
        for (int k = 0; k < 4; k++) begin
            r_d_p[k] <= $signed({1'b0, r_r_w[k]}) * w_h[k];
        end
    end

    // sum stage, floor by arithmetic shift
    assign w_sum = SUM_W'(r_d_p[0]) + SUM_W'(r_d_p[1]) + SUM_W'(r_d_p[2])
                 + SUM_W'(r_d_p[3]);

    always_ff @(posedge i_clk) begin
        r_s_data <= r_d_query ? w_sum[2*FRAC_W +: HGT_W] : '0;
    end

    assign o_res_push = r_vs;
    assign o_res_data = r_s_data;

endmodule

>>> rtl/hbs_checker.sv
// port-level checks of the sampler, bound to the top level
module hbs_checker import hbs_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    push,
    input logic                    full,
    input logic                    empty,
    input logic                    pop,
    input logic signed [HGT_W-1:0] o_height_out
);

    logic [15:0] r_pend;

    // transactions accepted and not yet taken out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 16'(push && !full) - 16'(pop && !empty);
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == '0) |-> empty)
        else $error("result shown with nothing outstanding");

    a_no_deadlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == '0) |-> !full)
        else $error("full with nothing outstanding");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_height_out)))
        else $error("stalled result changed");

endmodule

bind heightmap_bilinear_sampler_unit hbs_checker u_hbs_checker (.*);
